// ===== rtl/core/spni_pkg.sv =====
// ----------------------------------------------------------------------------
// spni_pkg
// Shared widths, codes, generator seeds and helper functions for the
// salt-and-pepper noise injector.
// ----------------------------------------------------------------------------
package spni_pkg;

	// Field widths
	localparam int PixW     = 8;
	localparam int PctW     = 7;
	localparam int GenW     = 32;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 7;

	// Partial residue of a 32-bit word mod 100 fits in 15 bits (max 27795)
	localparam int FoldW = 15;
	// Quotient of a folded value by 100 (max 277)
	localparam int QuotW = 9;
	// Final draw value, 0..99
	localparam int RemW  = 7;

	// Reciprocal of 100 for 15-bit dividends: q = (v * 41944) >> 22
	localparam int                 RecipW     = 16;
	localparam logic [RecipW-1:0]  RECIP_100  = 16'd41944;
	localparam int                 RecipShift = 22;
	localparam int                 ProdW      = FoldW + RecipW;

	localparam logic [PctW-1:0] DRAW_RANGE = 7'd100;
	localparam logic [PixW-1:0] PIX_FULL   = 8'hFF;
	localparam logic [PixW-1:0] PIX_ZERO   = 8'h00;

	// Noise mode codes
	localparam logic [1:0] MODE_SALT   = 2'd0;
	localparam logic [1:0] MODE_PEPPER = 2'd1;
	localparam logic [1:0] MODE_BOTH   = 2'd2;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_NOISE_MODE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SALT_PCT   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PEPPER_PCT = 2'd2;

	// Generator seeds
	localparam logic [GenW-1:0] SEED_X = 32'd123456789;
	localparam logic [GenW-1:0] SEED_Y = 32'd362436069;
	localparam logic [GenW-1:0] SEED_Z = 32'd521288629;
	localparam logic [GenW-1:0] SEED_W = 32'd88675123;

	typedef struct packed {
		logic [GenW-1:0] x;
		logic [GenW-1:0] y;
		logic [GenW-1:0] z;
		logic [GenW-1:0] w;
	} gen_state_t;

	// One xorshift128 step
	function automatic gen_state_t gen_step(gen_state_t s);
		logic [GenW-1:0] t;
		gen_state_t      n;
		t   = s.x ^ (s.x << 11);
		n.x = s.y;
		n.y = s.z;
		n.z = s.w;
		n.w = (s.w ^ (s.w >> 19)) ^ (t ^ (t >> 8));
		return n;
	endfunction

	// Fold a 32-bit word into a value with the same residue mod 100:
	// 256 = 56, 65536 = 36 and 2^24 = 16 (mod 100)
	function automatic logic [FoldW-1:0] fold_mod100(logic [GenW-1:0] v);
		logic [FoldW-1:0] acc;
		acc = FoldW'(v[7:0])
			+ FoldW'(v[15:8])  * FoldW'(56)
			+ FoldW'(v[23:16]) * FoldW'(36)
			+ FoldW'(v[31:24]) * FoldW'(16);
		return acc;
	endfunction

	// A rate takes part only in 1..100
	function automatic logic pct_active(logic [PctW-1:0] p);
		return (p != '0) && (p <= DRAW_RANGE);
	endfunction

endpackage

// ===== rtl/core/spni_if.sv =====
// ----------------------------------------------------------------------------
// spni_if
// Valid/ready channels of the noise injector: pixel in, pixel out and the
// register write port.
// ----------------------------------------------------------------------------
interface spni_in_if import spni_pkg::*;;
	logic            valid;
	logic            ready;
	logic [PixW-1:0] red_in;
	logic [PixW-1:0] green_in;
	logic [PixW-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

interface spni_out_if import spni_pkg::*;;
	logic            valid;
	logic            ready;
	logic [PixW-1:0] red_out;
	logic [PixW-1:0] green_out;
	logic [PixW-1:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface

interface spni_cfg_if import spni_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/salt_pepper_noise_injector_core.sv =====
// ----------------------------------------------------------------------------
// salt_pepper_noise_injector_core
// Salt-and-pepper noise on an RGB pixel stream, driven by an xorshift128
// generator.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  - one RGB pixel per request (valid/ready).
//   pix_out - one RGB pixel per request, in input order.
//   cfg     - register writes (0 noise_mode, 1 salt_percent, 2 pepper_percent),
//             always ready; write only while no pixels are in flight.
// Timing:
//   Accepted pixels pass stages 1 and 2 into the output register on pix_out.
//   Throughput is one pixel per clock while pix_out is not held. The three
//   stages are: generator step and mod-100 fold, reciprocal multiply,
//   remainder/compare/select into the output register. The generator itself
//   advances in the accept cycle, so back-to-back pixels see consecutive draws.
// Reset:
//   arst_n clears the pipeline, zeroes the registers and reseeds the
//   generator.
// Stall:
//   While pix_out is held, upstream stages keep filling their empty slots;
//   pix_in.ready drops only once all three stages hold a pixel.
// ----------------------------------------------------------------------------
module salt_pepper_noise_injector_core import spni_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	spni_cfg_if.sink    cfg,
	spni_in_if.sink     pix_in,
	spni_out_if.source  pix_out
);

	// Configuration registers
	logic [1:0]      mode_q;
	logic [PctW-1:0] salt_pct_q;
	logic [PctW-1:0] pepper_pct_q;

	// Generator
	gen_state_t gen_q;
	gen_state_t gen_one;
	gen_state_t gen_two;

	// Front end decode
	logic       in_acc;
	logic       salt_en;
	logic       pepper_en;
	logic [1:0] step_cnt;
	logic [GenW-1:0] pepper_word;

	// Stage 1
	logic             valid_s1;
	logic             salt_en_s1;
	logic             pepper_en_s1;
	logic [FoldW-1:0] salt_fold_s1;
	logic [FoldW-1:0] pepper_fold_s1;
	logic [PixW-1:0]  red_s1, green_s1, blue_s1;

	// Stage 2
	logic             valid_s2;
	logic             salt_en_s2;
	logic             pepper_en_s2;
	logic [FoldW-1:0] salt_fold_s2;
	logic [FoldW-1:0] pepper_fold_s2;
	logic [QuotW-1:0] salt_quot_s2;
	logic [QuotW-1:0] pepper_quot_s2;
	logic [PixW-1:0]  red_s2, green_s2, blue_s2;

	// Stage 3 (output register)
	logic            valid_s3;
	logic [PixW-1:0] red_s3, green_s3, blue_s3;

	// Flow control
	logic adv_s1, adv_s2, adv_s3;

	logic [ProdW-1:0] salt_prod;
	logic [ProdW-1:0] pepper_prod;
	logic [FoldW-1:0] salt_rem_full;
	logic [FoldW-1:0] pepper_rem_full;
	logic [RemW-1:0]  salt_rem;
	logic [RemW-1:0]  pepper_rem;
	logic             white;
	logic             black;

	// Stall propagates back only through full stages
	assign adv_s3       = !valid_s3 || pix_out.ready;
	assign adv_s2       = !valid_s2 || adv_s3;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign pix_in.ready = adv_s1;
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign cfg.ready    = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SALT;
			salt_pct_q   <= '0;
			pepper_pct_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_NOISE_MODE: mode_q       <= cfg.data[1:0];
				REG_SALT_PCT:   salt_pct_q   <= cfg.data;
				REG_PEPPER_PCT: pepper_pct_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Decide which draws this pixel takes
	always_comb begin
		salt_en   = 1'b0;
		pepper_en = 1'b0;
		unique case (mode_q)
			MODE_SALT:   salt_en   = pct_active(salt_pct_q);
			MODE_PEPPER: pepper_en = pct_active(pepper_pct_q);
			MODE_BOTH: begin
				salt_en   = pct_active(salt_pct_q) && pct_active(pepper_pct_q);
				pepper_en = salt_en;
			end
			default: ;
		endcase
	end

	assign step_cnt    = {1'b0, salt_en} + {1'b0, pepper_en};
	assign gen_one     = gen_step(gen_q);
	assign gen_two     = gen_step(gen_one);
	// Pepper takes the second draw when salt took the first
	assign pepper_word = salt_en ? gen_two.w : gen_one.w;

	// Advance the generator by the number of draws taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '{x: SEED_X, y: SEED_Y, z: SEED_Z, w: SEED_W};
		end else if (in_acc) begin
			unique case (step_cnt)
				2'd1:    gen_q <= gen_one;
				2'd2:    gen_q <= gen_two;
				default: gen_q <= gen_q;
			endcase
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_acc;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: capture pixel and folded draws
	always_ff @(posedge clk) begin
		if (in_acc) begin
			salt_en_s1     <= salt_en;
			pepper_en_s1   <= pepper_en;
			salt_fold_s1   <= fold_mod100(gen_one.w);
			pepper_fold_s1 <= fold_mod100(pepper_word);
			red_s1         <= pix_in.red_in;
			green_s1       <= pix_in.green_in;
			blue_s1        <= pix_in.blue_in;
		end
	end

	// Stage 2: quotient by 100 through the reciprocal
	assign salt_prod   = ProdW'(salt_fold_s1) * ProdW'(RECIP_100);
	assign pepper_prod = ProdW'(pepper_fold_s1) * ProdW'(RECIP_100);

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			salt_en_s2     <= salt_en_s1;
			pepper_en_s2   <= pepper_en_s1;
			salt_fold_s2   <= salt_fold_s1;
			pepper_fold_s2 <= pepper_fold_s1;
			salt_quot_s2   <= QuotW'(salt_prod >> RecipShift);
			pepper_quot_s2 <= QuotW'(pepper_prod >> RecipShift);
			red_s2         <= red_s1;
			green_s2       <= green_s1;
			blue_s2        <= blue_s1;
		end
	end

	// Stage 3: remainder, compare and select; pepper wins over salt
	assign salt_rem_full   = salt_fold_s2 - FoldW'(salt_quot_s2) * FoldW'(DRAW_RANGE);
	assign pepper_rem_full = pepper_fold_s2 - FoldW'(pepper_quot_s2) * FoldW'(DRAW_RANGE);
	assign salt_rem        = salt_rem_full[RemW-1:0];
	assign pepper_rem      = pepper_rem_full[RemW-1:0];
	assign white           = salt_en_s2 && (salt_rem < salt_pct_q);
	assign black           = pepper_en_s2 && (pepper_rem < pepper_pct_q);

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			priority if (black) begin
				red_s3   <= PIX_ZERO;
				green_s3 <= PIX_ZERO;
				blue_s3  <= PIX_ZERO;
			end else if (white) begin
				red_s3   <= PIX_FULL;
				green_s3 <= PIX_FULL;
				blue_s3  <= PIX_FULL;
			end else begin
				red_s3   <= red_s2;
				green_s3 <= green_s2;
				blue_s3  <= blue_s2;
			end
		end
	end

	assign pix_out.valid     = valid_s3;
	assign pix_out.red_out   = red_s3;
	assign pix_out.green_out = green_s3;
	assign pix_out.blue_out  = blue_s3;

`ifndef SYNTHESIS
	// Generator moves only on an accepted pixel that takes a draw
	a_gen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && (step_cnt != 2'd0)) |=> $stable(gen_q))
		else $error("generator advanced without a draw");

	// Reciprocal divide leaves a true remainder
	a_salt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (salt_rem_full < FoldW'(DRAW_RANGE)))
		else $error("salt draw remainder out of range");

	a_pepper_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (pepper_rem_full < FoldW'(DRAW_RANGE)))
		else $error("pepper draw remainder out of range");

	// An empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> pix_in.ready)
		else $error("input stalled with empty output register");

	// A stage holding a pixel under stall keeps it
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv_s2) |=> valid_s2)
		else $error("stage 2 pixel lost under stall");
`endif

endmodule
